FILE: sv/imu_caf_pkg.sv
// Shared constants, codes and helper functions for the IMU attitude filter.
package imu_caf_pkg;

  // Default number of CORDIC rotations.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_IDX_W       = 5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ROLL_OFS  = 2'd0;
  localparam logic [1:0] REG_PITCH_OFS = 2'd1;
  localparam logic [1:0] REG_GZ_BIAS   = 2'd2;

  // Angle constants in Q16 and Q8 degrees.
  localparam int HALF_TURN_Q16   = 11796480;
  localparam int QUARTER_TURN_Q8 = 23040;
  localparam int HALF_TURN_Q8    = 46080;
  localparam int FULL_TURN_Q8    = 92160;

  // Divisors and blend weight.
  localparam int DIV_RATE   = 131;
  localparam int DIV_MS     = 1000;
  localparam int DIV_BLEND  = 100;
  localparam int BLEND_KEEP = 98;
  localparam int MS_MAX     = 1000;
  localparam int MS_DEFAULT = 10;

  // Datapath widths.
  localparam int CW     = 40;  // CORDIC x and y
  localparam int ZW     = 26;  // CORDIC angle accumulator, Q16
  localparam int SQ_W   = 40;  // square root operand
  localparam int NUM_W  = 28;  // signed dividend
  localparam int DIV_W  = 27;  // dividend magnitude
  localparam int DIVR_W = 10;  // divisor half
  localparam int QUO_W  = 19;  // quotient magnitude

  // Reciprocals ceil(2^RECIP_SH / d); exact floor quotient for dividends below 2^DIV_W.
  localparam int     RECIP_SH    = 37;
  localparam longint RECIP_RATE  =
    ((longint'(1) <<< RECIP_SH) + longint'(DIV_RATE) - 1) / longint'(DIV_RATE);
  localparam longint RECIP_MS    =
    ((longint'(1) <<< RECIP_SH) + longint'(DIV_MS) - 1) / longint'(DIV_MS);
  localparam longint RECIP_BLEND =
    ((longint'(1) <<< RECIP_SH) + longint'(DIV_BLEND) - 1) / longint'(DIV_BLEND);

  // Rotation angles atan(2^-i) in Q16 degrees.
  function automatic logic [21:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [21:0] a;
    case (idx)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      5'd20: a = 22'd4;
      5'd21: a = 22'd2;
      5'd22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

  // Saturate a signed 20-bit value to signed 18 bits.
  function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
    logic signed [17:0] r;
    if (v > 20'sd131071) r = 18'sd131071;
    else if (v < -20'sd131072) r = -18'sd131072;
    else r = 18'(v);
    return r;
  endfunction

  // Saturate a signed 19-bit value to signed 17 bits.
  function automatic logic signed [16:0] sat17(input logic signed [18:0] v);
    logic signed [16:0] r;
    if (v > 19'sd65535) r = 17'sd65535;
    else if (v < -19'sd65536) r = -17'sd65536;
    else r = 17'(v);
    return r;
  endfunction

endpackage

FILE: sv/imu_complementary_attitude_filter_top.sv
// Complementary roll/pitch/yaw filter with shared CORDIC, root and divider units.
//
//  channel | dir | handshake                 | payload
//  in_     | in  | in_tvalid / in_tready     | in_tdata, 112 bits
//  out_    | out | out_tvalid / out_tready   | out_tdata, 104 bits
//  cfg_    | in  | cfg_valid / cfg_ready     | cfg_index 2 bits, cfg_data 17 bits
//
// A sample passes the root, two CORDIC passes and eight divisions before the next accept;
// the first sample after reset runs three divisions instead of eight, and an axis case
// skips the rotations of its CORDIC pass. Cost: 20 root steps, two CORDIC passes and
// eight divisions, S_LOAD to S_D_DONE, as reciprocal multiplies on the shared multiplier.
// Reset (rst_n low, synchronous) clears the filter state, offsets and bias.
// in_tready is high only between samples; a result waiting on out_tready
// holds the next sample only at its final output load.
module imu_complementary_attitude_filter_top #(
  parameter int CORDIC_STEPS = imu_caf_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // accel_x, accel_y, accel_z, rate_x_raw, rate_y_raw, rate_z_raw, elapsed_ms
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // roll_angle, pitch_angle, yaw_angle, rate_x, rate_y, rate_z_corrected
  output logic [103:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  localparam int STEP_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int CW       = imu_caf_pkg::CW;
  localparam int ZW       = imu_caf_pkg::ZW;
  localparam int SQ_W     = imu_caf_pkg::SQ_W;
  localparam int NUM_W    = imu_caf_pkg::NUM_W;
  localparam int DIV_W    = imu_caf_pkg::DIV_W;
  localparam int DIVR_W   = imu_caf_pkg::DIVR_W;
  localparam int QUO_W    = imu_caf_pkg::QUO_W;
  localparam int RECIP_SH = imu_caf_pkg::RECIP_SH;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ_A   = 4'd1;
  localparam logic [3:0] S_SQ_B   = 4'd2;
  localparam logic [3:0] S_SQRT   = 4'd3;
  localparam logic [3:0] S_C_INIT = 4'd4;
  localparam logic [3:0] S_C_RUN  = 4'd5;
  localparam logic [3:0] S_C_END  = 4'd6;
  localparam logic [3:0] S_LOAD   = 4'd7;
  localparam logic [3:0] S_D_INIT = 4'd8;
  localparam logic [3:0] S_D_RUN  = 4'd9;
  localparam logic [3:0] S_D_DONE = 4'd10;
  localparam logic [3:0] S_FINAL  = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  // Division jobs, in issue order.
  localparam logic [2:0] JOB_RX      = 3'd0;
  localparam logic [2:0] JOB_RY      = 3'd1;
  localparam logic [2:0] JOB_RZ      = 3'd2;
  localparam logic [2:0] JOB_INC_R   = 3'd3;
  localparam logic [2:0] JOB_INC_P   = 3'd4;
  localparam logic [2:0] JOB_INC_Y   = 3'd5;
  localparam logic [2:0] JOB_BLEND_R = 3'd6;
  localparam logic [2:0] JOB_BLEND_P = 3'd7;

  logic [3:0] state_r;
  logic [2:0] job_r;

  // Sample registers.
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic [10:0]        ms_r;
  logic [15:0]        in_ms;
  logic               ms_ok;

  // Configuration and filter state.
  logic signed [16:0] roll_ofs_r, pitch_ofs_r, gz_bias_r;
  logic signed [17:0] filt_roll_r, filt_pitch_r, filt_yaw_r;
  logic               have_first_r;

  // Intermediate results.
  logic signed [16:0] rx_r, ry_r, acc_roll_r, acc_pitch_r;
  logic signed [17:0] rz_r, inc_r_r, inc_p_r;
  logic [19:0]        mag_r;

  // Output stage.
  logic               out_tvalid_r;
  logic [103:0]       out_tdata_r;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign in_ms = in_tdata[111:96];
  assign ms_ok = (in_ms != 16'd0) && (in_ms <= 16'(imu_caf_pkg::MS_MAX));

  // Divider operands, used by the shared multiplier during S_D_RUN.
  logic [DIV_W-1:0]  dvd_r;
  logic [31:0]       div_m;

  // Shared multiplier, operands chosen by state and job.
  logic signed [27:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [59:0] prod;
  logic signed [18:0] gr, gp;

  assign gr   = 19'(filt_roll_r) + 19'(inc_r_r);
  assign gp   = 19'(filt_pitch_r) + 19'(inc_p_r);
  assign prod = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ_A: begin
        mul_a = 28'(ay_r);
        mul_b = 32'(ay_r);
      end
      S_SQ_B: begin
        mul_a = 28'(az_r);
        mul_b = 32'(az_r);
      end
      S_LOAD: begin
        case (job_r)
          JOB_INC_R: begin
            mul_a = 28'(rx_r);
            mul_b = {21'd0, ms_r};
          end
          JOB_INC_P: begin
            mul_a = 28'(ry_r);
            mul_b = {21'd0, ms_r};
          end
          JOB_INC_Y: begin
            mul_a = 28'(rz_r);
            mul_b = {21'd0, ms_r};
          end
          JOB_BLEND_R: begin
            mul_a = 28'(gr);
            mul_b = 32'(imu_caf_pkg::BLEND_KEEP);
          end
          JOB_BLEND_P: begin
            mul_a = 28'(gp);
            mul_b = 32'(imu_caf_pkg::BLEND_KEEP);
          end
          default: ;
        endcase
      end
      S_D_RUN: begin
        mul_a = $signed({1'b0, dvd_r});
        mul_b = $signed(div_m);
      end
      default: ;
    endcase
  end

  // Square root unit: bit by bit, moving sq_bit_r down two places in each S_SQRT step.
  logic [30:0]     sq_acc_r;
  logic [31:0]     sq_sum;
  logic [SQ_W-1:0] sq_v_r, sq_root_r, sq_bit_r;
  logic [SQ_W:0]   sq_t;
  logic            sq_ge;
  logic [SQ_W-1:0] sq_v_nxt, sq_root_nxt;

  assign sq_sum = {1'b0, sq_acc_r} + 32'(prod[31:0]);
  assign sq_t   = {1'b0, sq_root_r} + {1'b0, sq_bit_r};
  assign sq_ge  = ({1'b0, sq_v_r} >= sq_t);

  always_comb begin
    if (sq_ge) begin
      sq_v_nxt    = sq_v_r - sq_t[SQ_W-1:0];
      sq_root_nxt = (sq_root_r >> 1) + sq_bit_r;
    end else begin
      sq_v_nxt    = sq_v_r;
      sq_root_nxt = sq_root_r >> 1;
    end
  end

  // CORDIC vectoring unit: one rotation per cycle.
  logic                 cord_pass_r;
  logic [STEP_W-1:0]    iter_r;
  logic signed [CW-1:0] cx_r, cy_r, cxs, cys;
  logic signed [ZW-1:0] cz_r, cord_ang, cz_round, cord_sh;
  logic signed [20:0]   cin_y, cin_x, cx0, cy0;
  logic signed [16:0]   cord_sp, cord_res;
  logic                 cord_special;

  assign cin_y = cord_pass_r ? -(21'(ax_r) <<< 4) : 21'(ay_r);
  assign cin_x = cord_pass_r ? $signed({1'b0, mag_r}) : 21'(az_r);
  assign cx0   = cin_x[20] ? -cin_x : cin_x;
  assign cy0   = cin_x[20] ? -cin_y : cin_y;

  assign cxs      = cx_r >>> iter_r;
  assign cys      = cy_r >>> iter_r;
  assign cord_ang = $signed(ZW'(imu_caf_pkg::atan_q16(imu_caf_pkg::ATAN_IDX_W'(iter_r))));
  assign cz_round = cz_r + ZW'(128);
  assign cord_sh  = cz_round >>> 8;

  // Handle the axis cases exactly, without rotation.
  always_comb begin
    cord_special = 1'b1;
    cord_sp      = '0;
    if (cin_y == 21'sd0) begin
      cord_sp = cin_x[20] ? 17'(imu_caf_pkg::HALF_TURN_Q8) : 17'sd0;
    end else if (cin_x == 21'sd0) begin
      cord_sp = cin_y[20] ? -17'(imu_caf_pkg::QUARTER_TURN_Q8)
                          : 17'(imu_caf_pkg::QUARTER_TURN_Q8);
    end else begin
      cord_special = 1'b0;
    end
  end

  // Round to Q8 and limit to a half turn either way.
  always_comb begin
    if (cord_sh > ZW'(imu_caf_pkg::HALF_TURN_Q8))
      cord_res = 17'(imu_caf_pkg::HALF_TURN_Q8);
    else if (cord_sh < -ZW'(imu_caf_pkg::HALF_TURN_Q8))
      cord_res = -17'(imu_caf_pkg::HALF_TURN_Q8);
    else
      cord_res = 17'(cord_sh);
  end

  // Divider: reciprocal multiply on the shared multiplier, rounds half away from zero.
  logic signed [NUM_W-1:0] num_r, num_comb, num_abs;
  logic [DIVR_W-1:0]       div_h;
  logic [QUO_W-1:0]        quo_r;
  logic                    neg_r;
  logic signed [19:0]      div_q, div_res, rz_full, yw, yw_wrap;

  always_comb begin
    case (job_r)
      JOB_RX, JOB_RY, JOB_RZ: begin
        div_m = 32'(imu_caf_pkg::RECIP_RATE);
        div_h = DIVR_W'(imu_caf_pkg::DIV_RATE / 2);
      end
      JOB_INC_R, JOB_INC_P, JOB_INC_Y: begin
        div_m = 32'(imu_caf_pkg::RECIP_MS);
        div_h = DIVR_W'(imu_caf_pkg::DIV_MS / 2);
      end
      default: begin
        div_m = 32'(imu_caf_pkg::RECIP_BLEND);
        div_h = DIVR_W'(imu_caf_pkg::DIV_BLEND / 2);
      end
    endcase
  end

  // Select the dividend for each job.
  always_comb begin
    case (job_r)
      JOB_RX:      num_comb = NUM_W'(gx_r) <<< 8;
      JOB_RY:      num_comb = NUM_W'(gy_r) <<< 8;
      JOB_RZ:      num_comb = NUM_W'(gz_r) <<< 8;
      JOB_BLEND_R: num_comb = NUM_W'(prod) + (NUM_W'(acc_roll_r) <<< 1);
      JOB_BLEND_P: num_comb = NUM_W'(prod) + (NUM_W'(acc_pitch_r) <<< 1);
      default:     num_comb = NUM_W'(prod);
    endcase
  end

  assign num_abs = num_r[NUM_W-1] ? -num_r : num_r;
  assign div_q   = $signed({1'b0, quo_r});
  assign div_res = neg_r ? -div_q : div_q;
  assign rz_full = div_res - 20'(gz_bias_r);
  assign yw      = 20'(filt_yaw_r) + div_res;

  // Wrap yaw once into a half turn either way.
  always_comb begin
    if (yw > 20'(imu_caf_pkg::HALF_TURN_Q8))
      yw_wrap = yw - 20'(imu_caf_pkg::FULL_TURN_Q8);
    else if (yw < -20'(imu_caf_pkg::HALF_TURN_Q8))
      yw_wrap = yw + 20'(imu_caf_pkg::FULL_TURN_Q8);
    else
      yw_wrap = yw;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_ofs_r  <= '0;
      pitch_ofs_r <= '0;
      gz_bias_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        imu_caf_pkg::REG_ROLL_OFS:  roll_ofs_r  <= cfg_data;
        imu_caf_pkg::REG_PITCH_OFS: pitch_ofs_r <= cfg_data;
        imu_caf_pkg::REG_GZ_BIAS:   gz_bias_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_first_r <= 1'b0;
      filt_roll_r  <= '0;
      filt_pitch_r <= '0;
      filt_yaw_r   <= '0;
      out_tvalid_r <= 1'b0;
      job_r        <= JOB_RX;
      cord_pass_r  <= 1'b0;
      iter_r       <= '0;
    end else begin
      // Drop the result once it is transferred, unless a new one loads now.
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) out_tvalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ax_r    <= in_tdata[15:0];
            ay_r    <= in_tdata[31:16];
            az_r    <= in_tdata[47:32];
            gx_r    <= in_tdata[63:48];
            gy_r    <= in_tdata[79:64];
            gz_r    <= in_tdata[95:80];
            ms_r    <= ms_ok ? in_ms[10:0] : 11'(imu_caf_pkg::MS_DEFAULT);
            state_r <= S_SQ_A;
          end
        end
        S_SQ_A: begin
          sq_acc_r <= prod[30:0];
          state_r  <= S_SQ_B;
        end
        S_SQ_B: begin
          sq_v_r    <= {sq_sum, 8'd0};
          sq_root_r <= '0;
          sq_bit_r  <= SQ_W'(1) << (SQ_W - 2);
          state_r   <= S_SQRT;
        end
        S_SQRT: begin
          sq_v_r    <= sq_v_nxt;
          sq_root_r <= sq_root_nxt;
          sq_bit_r  <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            mag_r       <= sq_root_nxt[19:0];
            cord_pass_r <= 1'b0;
            state_r     <= S_C_INIT;
          end
        end
        S_C_INIT: begin
          iter_r <= '0;
          if (cord_special) begin
            cz_r    <= ZW'(cord_sp) <<< 8;
            state_r <= S_C_END;
          end else begin
            cx_r <= CW'(cx0) <<< 16;
            cy_r <= CW'(cy0) <<< 16;
            if (cin_x[20])
              cz_r <= cin_y[20] ? -ZW'(imu_caf_pkg::HALF_TURN_Q16)
                                : ZW'(imu_caf_pkg::HALF_TURN_Q16);
            else
              cz_r <= '0;
            state_r <= S_C_RUN;
          end
        end
        S_C_RUN: begin
          if (!cy_r[CW-1]) begin
            cx_r <= cx_r + cys;
            cy_r <= cy_r - cxs;
            cz_r <= cz_r + cord_ang;
          end else begin
            cx_r <= cx_r - cys;
            cy_r <= cy_r + cxs;
            cz_r <= cz_r - cord_ang;
          end
          iter_r <= iter_r + STEP_W'(1);
          if (iter_r == STEP_W'(CORDIC_STEPS - 1)) state_r <= S_C_END;
        end
        S_C_END: begin
          if (!cord_pass_r) begin
            acc_roll_r  <= cord_res;
            cord_pass_r <= 1'b1;
            state_r     <= S_C_INIT;
          end else begin
            acc_pitch_r <= cord_res;
            job_r       <= JOB_RX;
            state_r     <= S_LOAD;
          end
        end
        S_LOAD: begin
          num_r   <= num_comb;
          state_r <= S_D_INIT;
        end
        S_D_INIT: begin
          neg_r   <= num_r[NUM_W-1];
          dvd_r   <= num_abs[DIV_W-1:0] + DIV_W'(div_h);
          state_r <= S_D_RUN;
        end
        S_D_RUN: begin
          quo_r   <= prod[RECIP_SH +: QUO_W];
          state_r <= S_D_DONE;
        end
        S_D_DONE: begin
          job_r   <= job_r + 3'd1;
          state_r <= S_LOAD;
          case (job_r)
            JOB_RX: rx_r <= 17'(div_res);
            JOB_RY: ry_r <= 17'(div_res);
            JOB_RZ: begin
              rz_r <= imu_caf_pkg::sat18(rz_full);
              if (!have_first_r) state_r <= S_FINAL;
            end
            JOB_INC_R:   inc_r_r <= 18'(div_res);
            JOB_INC_P:   inc_p_r <= 18'(div_res);
            JOB_INC_Y:   filt_yaw_r <= imu_caf_pkg::sat18(yw_wrap);
            JOB_BLEND_R: filt_roll_r <= imu_caf_pkg::sat18(div_res);
            default: begin
              filt_pitch_r <= imu_caf_pkg::sat18(div_res);
              state_r      <= S_FINAL;
            end
          endcase
        end
        S_FINAL: begin
          // Seed the filter from the accelerometer on the first sample.
          if (!have_first_r) begin
            filt_roll_r  <= 18'(acc_roll_r);
            filt_pitch_r <= 18'(acc_pitch_r);
            filt_yaw_r   <= '0;
            have_first_r <= 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Load the output register once it is free.
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r <= {
              rz_r, ry_r, rx_r, filt_yaw_r,
              imu_caf_pkg::sat17(19'(filt_pitch_r) - 19'(pitch_ofs_r)),
              imu_caf_pkg::sat17(19'(filt_roll_r) - 19'(roll_ofs_r))
            };
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SQ_A))
    else $error("accepted sample did not start the sequence");

  a_div_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_DONE) |-> ($past(state_r) == S_D_RUN))
    else $error("division ended early");

  a_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> have_first_r)
    else $error("result without seeded filter state");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output load");

endmodule
